### design/olt_pkg.sv
// shared types and constants for the occupancy lamp timeout controller
`default_nettype none

package olt_pkg;

  // field widths
  localparam int unsigned DIST_W     = 16;
  localparam int unsigned TIMEOUT_W  = 32;
  localparam int unsigned LEVEL_W    = 7;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // divider sizing: dist * 100 fits in 23 bits, quotient never above 100
  localparam int unsigned NUM_W  = 23;
  localparam int unsigned QUOT_W = 7;
  localparam int unsigned IDX_W  = 3;

  // full scale percent, also the distance scale factor
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 7'd100;

  // distance change that counts as movement
  localparam logic [DIST_W-1:0] MOTION_BAND = 16'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SECURITY = 3'd0,
    REG_MAX_DIST = 3'd1,
    REG_TIMEOUT  = 3'd2,
    REG_CEILING  = 3'd3,
    REG_FLOOR    = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_MUL  = 2'd1,
    ST_DIV  = 2'd2,
    ST_UPD  = 2'd3
  } ctrl_state_e;

  typedef struct packed {
    logic             capture;
    logic             mult;
    logic             div_step;
    logic [IDX_W-1:0] div_idx;
    logic             commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_div;
  } dp_status_t;

endpackage

`default_nettype wire

### design/olt_ctrl.sv
// sequencing state machine: capture, scale, divide steps, state commit
`default_nettype none

module olt_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  input  wire olt_pkg::dp_status_t status_i,
  output olt_pkg::ctrl_cmd_t      cmd_o
);

  olt_pkg::ctrl_state_e state_q, state_d;
  logic [olt_pkg::IDX_W-1:0] idx_q, idx_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      olt_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = olt_pkg::ST_MUL;
      end
      olt_pkg::ST_MUL: begin
        state_d = status_i.need_div ? olt_pkg::ST_DIV : olt_pkg::ST_UPD;
      end
      olt_pkg::ST_DIV: begin
        if (idx_q == '0) state_d = olt_pkg::ST_UPD;
      end
      olt_pkg::ST_UPD: begin
        if (out_free) state_d = olt_pkg::ST_IDLE;
      end
      default: state_d = olt_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o          = '0;
    cmd_o.div_idx  = idx_q;
    in_ready_o     = 1'b0;
    case (state_q)
      olt_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      olt_pkg::ST_MUL: cmd_o.mult = 1'b1;
      olt_pkg::ST_DIV: cmd_o.div_step = 1'b1;
      olt_pkg::ST_UPD: cmd_o.commit = out_free;
      default: cmd_o = '0;
    endcase
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_o.mult) begin
      idx_d = olt_pkg::IDX_W'(olt_pkg::QUOT_W - 1);
    end else if (cmd_o.div_step && idx_q != '0) begin
      idx_d = idx_q - 1'b1;
    end
  end

  assign out_valid_d = cmd_o.commit || (out_valid_q && !out_ready_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= olt_pkg::ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

### design/olt_dp.sv
// datapath: config registers, input capture, percent divider, lamp and timer state
`default_nettype none

module olt_dp #(
  parameter int unsigned ELAPSED_BITS = 32
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  input  wire logic [olt_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [olt_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire logic                              func_i,
  input  wire logic [olt_pkg::DIST_W-1:0]        distance_i,
  input  wire olt_pkg::ctrl_cmd_t                cmd_i,
  output olt_pkg::dp_status_t                    status_o,
  output logic                                   lamp_on_o,
  output logic [olt_pkg::LEVEL_W-1:0]            lamp_level_o,
  output logic                                   alarm_active_o,
  output logic                                   hold_running_o
);

  localparam int unsigned CMP_W = (ELAPSED_BITS > olt_pkg::TIMEOUT_W) ?
                                  ELAPSED_BITS : olt_pkg::TIMEOUT_W;

  // config registers
  logic                            sec_q;
  logic [olt_pkg::DIST_W-1:0]      max_q;
  logic [olt_pkg::TIMEOUT_W-1:0]   timeout_q;
  logic [olt_pkg::LEVEL_W-1:0]     ceil_q;
  logic [olt_pkg::LEVEL_W-1:0]     floor_q;

  // captured word and divider
  logic                            func_q;
  logic [olt_pkg::DIST_W-1:0]      dist_q;
  logic [olt_pkg::NUM_W-1:0]       num_q;
  logic [olt_pkg::QUOT_W-1:0]      quot_q;
  logic [olt_pkg::NUM_W-1:0]       trial;

  // lamp and timer state
  logic                            lamp_q, lamp_d;
  logic [olt_pkg::LEVEL_W-1:0]     level_q, level_d;
  logic                            alarm_q, alarm_d;
  logic                            timer_q, timer_d;
  logic [ELAPSED_BITS-1:0]         elapsed_q, elapsed_d;
  logic [olt_pkg::DIST_W-1:0]      ref_q, ref_d;
  logic [olt_pkg::DIST_W-1:0]      blk_q, blk_d;
  logic                            blk_valid_q, blk_valid_d;

  logic                            in_range;
  logic [olt_pkg::DIST_W-1:0]      diff_blk, diff_ref;
  logic                            moved_blk, moved_ref, expired;
  logic [olt_pkg::LEVEL_W-1:0]     ceil_c, floor_c, lvl_raw, lvl_top, lvl_fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_q     <= 1'b0;
      max_q     <= '0;
      timeout_q <= '0;
      ceil_q    <= olt_pkg::LEVEL_MAX;
      floor_q   <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        olt_pkg::REG_SECURITY: sec_q     <= cfg_data_i[0];
        olt_pkg::REG_MAX_DIST: max_q     <= cfg_data_i[olt_pkg::DIST_W-1:0];
        olt_pkg::REG_TIMEOUT:  timeout_q <= cfg_data_i[olt_pkg::TIMEOUT_W-1:0];
        olt_pkg::REG_CEILING:  ceil_q    <= cfg_data_i[olt_pkg::LEVEL_W-1:0];
        olt_pkg::REG_FLOOR:    floor_q   <= cfg_data_i[olt_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_range = dist_q <= max_q;
  assign status_o.need_div = !func_q && !sec_q && in_range && (max_q != '0);

  // restoring divide, one quotient bit per step, msb first
  assign trial = olt_pkg::NUM_W'(max_q) << cmd_i.div_idx;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= func_i;
      dist_q <= distance_i;
    end
    if (cmd_i.mult) begin
      num_q  <= olt_pkg::NUM_W'(dist_q) * olt_pkg::NUM_W'(olt_pkg::LEVEL_MAX);
      quot_q <= '0;
    end else if (cmd_i.div_step && num_q >= trial) begin
      num_q                 <= num_q - trial;
      quot_q[cmd_i.div_idx] <= 1'b1;
    end
  end

  assign diff_blk  = (dist_q >= blk_q) ? (dist_q - blk_q) : (blk_q - dist_q);
  assign diff_ref  = (dist_q >= ref_q) ? (dist_q - ref_q) : (ref_q - dist_q);
  assign moved_blk = diff_blk >= olt_pkg::MOTION_BAND;
  assign moved_ref = diff_ref >= olt_pkg::MOTION_BAND;
  assign expired   = CMP_W'(elapsed_q) >= CMP_W'(timeout_q);

  // clamp registers saturate at full scale, floor applied last
  assign ceil_c  = (ceil_q > olt_pkg::LEVEL_MAX) ? olt_pkg::LEVEL_MAX : ceil_q;
  assign floor_c = (floor_q > olt_pkg::LEVEL_MAX) ? olt_pkg::LEVEL_MAX : floor_q;
  assign lvl_raw = olt_pkg::LEVEL_MAX - quot_q;
  assign lvl_top = (lvl_raw > ceil_c) ? ceil_c : lvl_raw;
  assign lvl_fin = (lvl_top < floor_c) ? floor_c : lvl_top;

  always_comb begin
    lamp_d      = lamp_q;
    level_d     = level_q;
    alarm_d     = alarm_q;
    timer_d     = timer_q;
    elapsed_d   = elapsed_q;
    ref_d       = ref_q;
    blk_d       = blk_q;
    blk_valid_d = blk_valid_q;
    if (func_q) begin
      if (timer_q && elapsed_q != '1) elapsed_d = elapsed_q + 1'b1;
    end else begin
      if (sec_q && in_range) begin
        alarm_d = 1'b1;
      end else if (!sec_q) begin
        alarm_d = 1'b0;
      end
      if (!sec_q && in_range) begin
        if (!blk_valid_q || moved_blk) begin
          level_d     = lvl_fin;
          blk_valid_d = 1'b0;
          if (timer_q) begin
            if (moved_ref) begin
              ref_d     = dist_q;
              elapsed_d = '0;
            end else if (expired) begin
              lamp_d      = 1'b0;
              timer_d     = 1'b0;
              elapsed_d   = '0;
              ref_d       = '0;
              blk_d       = dist_q;
              blk_valid_d = 1'b1;
            end
          end else begin
            lamp_d = 1'b1;
            if (timeout_q != '0) begin
              ref_d   = dist_q;
              timer_d = 1'b1;
            end
          end
        end
      end else begin
        lamp_d    = 1'b0;
        timer_d   = 1'b0;
        elapsed_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lamp_q      <= 1'b0;
      level_q     <= '0;
      alarm_q     <= 1'b0;
      timer_q     <= 1'b0;
      elapsed_q   <= '0;
      ref_q       <= '0;
      blk_q       <= '0;
      blk_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      lamp_q      <= lamp_d;
      level_q     <= level_d;
      alarm_q     <= alarm_d;
      timer_q     <= timer_d;
      elapsed_q   <= elapsed_d;
      ref_q       <= ref_d;
      blk_q       <= blk_d;
      blk_valid_q <= blk_valid_d;
    end
  end

  assign lamp_on_o      = lamp_q;
  assign lamp_level_o   = level_q;
  assign alarm_active_o = alarm_q;
  assign hold_running_o = timer_q;

endmodule

`default_nettype wire

### design/occupancy_lamp_timeout_controller.sv
// top level of the occupancy lamp timeout controller
// Each input word is either a distance sample (func 0) or one time tick (func 1),
// and each one returns exactly one output word showing lamp, level, alarm and
// hold timer state after the word is applied. Words are handled one at a time:
// a tick or a sample that needs no divide goes through capture, scale and commit
// before out_valid_o rises, while an in-range lighting sample with a nonzero max
// distance also runs the 7-step restoring divider that forms the distance percent
// (one quotient bit per cycle). The next word is taken in the cycle after a
// result is committed. A finished word sits in the state registers behind
// out_valid_o while the next word is already accepted; the new result is
// committed only once the previous one has been taken, so a held output
// stalls the input after one more word.
// Configuration writes are always taken (cfg_ready_o is tied high) and must
// only be issued while no word is in flight; indexes beyond the register list
// are ignored.
`default_nettype none

module occupancy_lamp_timeout_controller #(
  parameter int unsigned ELAPSED_BITS = 32  // width of the saturating tick counter
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // input words
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic                           func_i,
  input  wire logic [olt_pkg::DIST_W-1:0]     distance_i,
  // output words
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic                                lamp_on_o,
  output logic [olt_pkg::LEVEL_W-1:0]         lamp_level_o,
  output logic                                alarm_active_o,
  output logic                                hold_running_o,
  // config writes
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [olt_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [olt_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  olt_pkg::ctrl_cmd_t  cmd;
  olt_pkg::dp_status_t status;

  // register writes never stall
  assign cfg_ready_o = 1'b1;

  // sequencer: capture, scale by 100, divide when needed, commit
  olt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // config, divider and lamp/timer state; state registers double as output word
  olt_dp #(
    .ELAPSED_BITS (ELAPSED_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .func_i         (func_i),
    .distance_i     (distance_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .lamp_on_o      (lamp_on_o),
    .lamp_level_o   (lamp_level_o),
    .alarm_active_o (alarm_active_o),
    .hold_running_o (hold_running_o)
  );

endmodule

`default_nettype wire

### design/olt_checker.sv
// port-level checks for the occupancy lamp timeout controller, bound to the top
`default_nettype none

module olt_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_valid_i,
  input wire logic                       in_ready_o,
  input wire logic                       out_valid_o,
  input wire logic                       out_ready_i,
  input wire logic                       lamp_on_o,
  input wire logic [olt_pkg::LEVEL_W-1:0] lamp_level_o,
  input wire logic                       alarm_active_o,
  input wire logic                       hold_running_o
);

  // a pending output word is not withdrawn
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output word dropped before it was taken");

  // one word in flight at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second word accepted while one is in flight");

  // lamp and alarm are never both on in a valid output word
  a_lamp_alarm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(lamp_on_o && alarm_active_o))
    else $error("lamp lit while alarm active");

  // in a valid output word the hold timer only runs with the lamp lit
  a_hold_lamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hold_running_o |-> lamp_on_o)
    else $error("hold timer running with lamp off");

  // level stays within percent range
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> lamp_level_o <= olt_pkg::LEVEL_MAX)
    else $error("lamp level above full scale");

endmodule

bind occupancy_lamp_timeout_controller olt_checker u_olt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .lamp_on_o      (lamp_on_o),
  .lamp_level_o   (lamp_level_o),
  .alarm_active_o (alarm_active_o),
  .hold_running_o (hold_running_o)
);

`default_nettype wire
